// ===== src/brf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared constants, types and index helpers for the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int IDX_W     = 6;
    localparam int DEPTH     = 2 ** IDX_W;
    localparam int SIZE_W    = IDX_W + 1;
    localparam int CNT_W     = 5;
    localparam int MAX_BURST = 16;

    localparam logic [2:0] REQ_PUSH      = 3'd0;
    localparam logic [2:0] REQ_POP       = 3'd1;
    localparam logic [2:0] REQ_PEND_HEAD = 3'd2;
    localparam logic [2:0] REQ_PEND_CONT = 3'd3;
    localparam logic [2:0] REQ_CONFIRM   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s < SIZE_W'(2))
        begin
            r = SIZE_W'(2);
        end
        else if (s > SIZE_W'(DEPTH))
        begin
            r = SIZE_W'(DEPTH);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_advance(input logic [IDX_W-1:0] i,
                                                     input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] n;
        n = {1'b0, i} + SIZE_W'(1);
        return (n >= sz) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0)
        begin
            r = CNT_W'(1);
        end
        else if (c > CNT_W'(MAX_BURST))
        begin
            r = CNT_W'(MAX_BURST);
        end
        return r;
    endfunction

endpackage

// ===== src/byte_ring_fifo_with_pending_read_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_pending_read_top
// Circular byte FIFO with pop bursts, look-ahead bursts and commit.
//
//   channel | direction | handshake                   | payload
//   in      | sink      | in_valid / in_stall         | req_type, push_data, burst_count
//   out     | source    | out_valid / out_stall       | read_data, ok, last
//   cfg     | sink      | cfg_wr_en (no wait)         | cfg_wr_data (ring_size)
//
// Push, confirm and unknown requests: one registered result each.
// Bursts: request decode, then the first ring read, then one byte per cycle
// while out is not stalled; a stop on empty after some bytes passes S_FETCH again.
// New requests are held off until the burst ends and the result register is free.
// Reset empties the ring (all indices 0) and sets ring_size to 64.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_pending_read_top
    import brf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        req_type,
    input  logic [7:0]        push_data,
    input  logic [CNT_W-1:0]  burst_count,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        read_data,
    output logic              ok,
    output logic              last,

    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        mem_q;
    logic              mem_we;
    logic              mem_re;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0]  wr_reg, wr_next;
    logic [IDX_W-1:0]  rd_reg, rd_next;
    logic [IDX_W-1:0]  la_reg, la_next;
    logic              sel_la_reg, sel_la_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        data_reg, data_next;
    logic              ok_reg, ok_next;
    logic              last_reg, last_next;

    logic [SIZE_W-1:0] sz;
    logic [IDX_W-1:0]  ptr;
    logic [IDX_W-1:0]  ptr_adv;
    logic [IDX_W-1:0]  wr_adv;
    logic              out_free;
    logic              in_take;

    assign sz       = eff_size(size_reg);
    assign ptr      = sel_la_reg ? la_reg : rd_reg;
    assign ptr_adv  = idx_advance(ptr, sz);
    assign wr_adv   = idx_advance(wr_reg, sz);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign read_data = data_reg;
    assign ok        = ok_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        la_next        = la_reg;
        sel_la_next    = sel_la_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_next      = data_reg;
        ok_next        = ok_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (req_type)
                        REQ_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            data_next      = '0;
                            last_next      = 1'b1;
                            if (wr_adv != rd_reg)
                            begin
                                mem_we  = 1'b1;
                                wr_next = wr_adv;
                                ok_next = 1'b1;
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        REQ_POP:
                        begin
                            sel_la_next = 1'b0;
                            rem_next    = clamp_count(burst_count);
                            state_next  = S_FETCH;
                        end
                        REQ_PEND_HEAD:
                        begin
                            la_next     = rd_reg;
                            sel_la_next = 1'b1;
                            rem_next    = clamp_count(burst_count);
                            state_next  = S_FETCH;
                        end
                        REQ_PEND_CONT:
                        begin
                            sel_la_next = 1'b1;
                            rem_next    = clamp_count(burst_count);
                            state_next  = S_FETCH;
                        end
                        REQ_CONFIRM:
                        begin
                            rd_next        = la_reg;
                            out_valid_next = 1'b1;
                            data_next      = '0;
                            ok_next        = 1'b1;
                            last_next      = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            data_next      = '0;
                            ok_next        = 1'b0;
                            last_next      = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (ptr == wr_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        data_next      = '0;
                        ok_next        = 1'b0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mem_re = 1'b1;
                    if (sel_la_reg)
                    begin
                        la_next = ptr_adv;
                    end
                    else
                    begin
                        rd_next = ptr_adv;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_next      = mem_q;
                    ok_next        = 1'b1;
                    last_next      = (rem_reg == CNT_W'(1));
                    rem_next       = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else if (ptr != wr_reg)
                    begin
                        // next byte read overlaps this emit
                        mem_re = 1'b1;
                        if (sel_la_reg)
                        begin
                            la_next = ptr_adv;
                        end
                        else
                        begin
                            rd_next = ptr_adv;
                        end
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            size_next = cfg_wr_data;
            wr_next   = '0;
            rd_next   = '0;
            la_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_reg] <= push_data;
        end
        if (mem_re)
        begin
            mem_q <= mem[ptr];
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        ok_reg   <= ok_next;
        last_reg <= last_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_W'(DEPTH);
            wr_reg        <= '0;
            rd_reg        <= '0;
            la_reg        <= '0;
            sel_la_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            la_reg        <= la_next;
            sel_la_reg    <= sel_la_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sim/brf_fifo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_fifo_checker
// Watches the request, reply and size-write ports of the byte ring FIFO,
// keeps its own copy of the ring and its three indices, queues the replies
// each accepted request must give and compares every accepted reply in order.
// ----------------------------------------------------------------------------
module brf_fifo_checker
    import brf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [2:0]        req_type,
    input  logic [7:0]        push_data,
    input  logic [CNT_W-1:0]  burst_count,

    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        read_data,
    input  logic              ok,
    input  logic              last,

    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,

    output int                mismatch_count,
    output int                outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       ok;
        logic       last;
    } reply_t;

    logic [7:0]        ring_mem [DEPTH];
    logic [IDX_W-1:0]  wr_ptr;
    logic [IDX_W-1:0]  rd_ptr;
    logic [IDX_W-1:0]  la_ptr;
    logic [SIZE_W-1:0] ring_slots;
    reply_t            replies_due [$];
    reply_t            want;
    int                errors;

    function automatic logic [SIZE_W-1:0] slots_in_use();
        logic [SIZE_W-1:0] sz;
        sz = ring_slots;
        if (sz < SIZE_W'(2))
        begin
            sz = SIZE_W'(2);
        end
        if (sz > SIZE_W'(DEPTH))
        begin
            sz = SIZE_W'(DEPTH);
        end
        return sz;
    endfunction

    function automatic logic [IDX_W-1:0] step_slot(input logic [IDX_W-1:0] i,
                                                   input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] n;
        n = SIZE_W'(i) + SIZE_W'(1);
        return (n >= sz) ? '0 : n[IDX_W-1:0];
    endfunction

    task automatic due(input logic [7:0] d, input logic o, input logic l);
        reply_t r;
        r.data = d;
        r.ok   = o;
        r.last = l;
        replies_due.push_back(r);
    endtask

    task automatic predict_request(input logic [2:0]       kind,
                                   input logic [7:0]       byte_in,
                                   input logic [CNT_W-1:0] cnt_in);
        logic [SIZE_W-1:0] sz;
        logic [IDX_W-1:0]  cur;
        int                n;
        sz = slots_in_use();
        if (cnt_in == '0)
        begin
            n = 1;
        end
        else if (cnt_in > CNT_W'(MAX_BURST))
        begin
            n = MAX_BURST;
        end
        else
        begin
            n = int'(cnt_in);
        end
        case (kind)
            REQ_PUSH:
            begin
                cur = step_slot(wr_ptr, sz);
                if (cur != rd_ptr)
                begin
                    ring_mem[wr_ptr] = byte_in;
                    wr_ptr = cur;
                    due(8'h00, 1'b1, 1'b1);
                end
                else
                begin
                    due(8'h00, 1'b0, 1'b1);
                end
            end
            REQ_CONFIRM:
            begin
                rd_ptr = la_ptr;
                due(8'h00, 1'b1, 1'b1);
            end
            REQ_POP, REQ_PEND_HEAD, REQ_PEND_CONT:
            begin
                if (kind == REQ_PEND_HEAD)
                begin
                    la_ptr = rd_ptr;
                end
                for (int k = 0; k < n; k++)
                begin
                    cur = (kind == REQ_POP) ? rd_ptr : la_ptr;
                    if (cur == wr_ptr)
                    begin
                        due(8'h00, 1'b0, 1'b1);
                        break;
                    end
                    due(ring_mem[cur], 1'b1, k == n - 1);
                    if (kind == REQ_POP)
                    begin
                        rd_ptr = step_slot(cur, sz);
                    end
                    else
                    begin
                        la_ptr = step_slot(cur, sz);
                    end
                end
            end
            default:
            begin
                due(8'h00, 1'b0, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ring_mem[i] = 8'h00;
            end
            wr_ptr     = '0;
            rd_ptr     = '0;
            la_ptr     = '0;
            ring_slots = SIZE_W'(DEPTH);
            errors     = 0;
            replies_due.delete();
            outstanding    <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: reply with no request pending: data=%02h ok=%0d last=%0d",
                                 $realtime, read_data, ok, last);
                    end
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (want.data !== read_data || want.ok !== ok || want.last !== last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: reply mismatch: exp data=%02h ok=%0d last=%0d, got data=%02h ok=%0d last=%0d",
                                     $realtime, want.data, want.ok, want.last,
                                     read_data, ok, last);
                        end
                    end
                end
            end
            if (cfg_wr_en)
            begin
                ring_slots = cfg_wr_data;
                wr_ptr     = '0;
                rd_ptr     = '0;
                la_ptr     = '0;
            end
            if (in_valid && !in_stall)
            begin
                predict_request(req_type, push_data, burst_count);
            end
            outstanding    <= replies_due.size();
            mismatch_count <= errors;
        end
    end

endmodule

// ===== sim/tb_byte_ring_fifo_with_pending_read_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_pending_read_top
// Drives the byte ring FIFO with random request and reply gaps: first writes
// every ring slot and runs full, wrap and empty-stop cases, then directed
// corner requests, then random request mixes under several ring sizes,
// including a long reply hold-off. Replies are checked by brf_fifo_checker.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_pending_read_top;
    import brf_pkg::*;

    localparam int         CLK_PERIOD   = 20;
    localparam int         GAP_MAX      = 18;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         PHASE_ITEMS  = 6;
    localparam int         NUM_PHASES   = 7;
    localparam logic [2:0] REQ_CODE_MAX = 3'd7;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [2:0]        req_type    = REQ_PUSH;
    logic [7:0]        push_data   = 8'h00;
    logic [CNT_W-1:0]  burst_count = CNT_W'(1);
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [7:0]        read_data;
    logic              ok;
    logic              last;
    logic              cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = SIZE_W'(DEPTH);

    int                mismatch_count;
    int                outstanding;
    bit                calm        = 1'b0;
    bit                hold_output = 1'b0;

    logic [SIZE_W-1:0] phase_sizes [NUM_PHASES];

    always #(CLK_PERIOD / 2) clk = ~clk;

    byte_ring_fifo_with_pending_read_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .push_data   (push_data),
        .burst_count (burst_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .ok          (ok),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    brf_fifo_checker fifo_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .push_data      (push_data),
        .burst_count    (burst_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .ok             (ok),
        .last           (last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    task automatic send(input logic [2:0]       kind,
                        input logic [7:0]       byte_in,
                        input logic [CNT_W-1:0] cnt_in);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        push_data   <= byte_in;
        burst_count <= cnt_in;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random();
        int               pick;
        logic [2:0]       kind;
        logic [CNT_W-1:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            kind = REQ_PUSH;
        end
        else if (pick < 60)
        begin
            kind = REQ_POP;
        end
        else if (pick < 72)
        begin
            kind = REQ_PEND_HEAD;
        end
        else if (pick < 84)
        begin
            kind = REQ_PEND_CONT;
        end
        else if (pick < 95)
        begin
            kind = REQ_CONFIRM;
        end
        else
        begin
            kind = 3'($urandom_range(REQ_CONFIRM + 1, REQ_CODE_MAX));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            cnt = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        end
        else
        begin
            cnt = CNT_W'($urandom_range(1, MAX_BURST));
        end
        send(kind, 8'($urandom_range(0, 255)), cnt);
    endtask

    // wait until every reply is in
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_ring_size(input logic [SIZE_W-1:0] slots);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= slots;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : receiver
        int w;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                w = HOLD_CYCLES;
            end
            else
            begin
                w = draw_gap();
            end
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        phase_sizes[0] = SIZE_W'(2);
        phase_sizes[1] = SIZE_W'(DEPTH);
        phase_sizes[2] = SIZE_W'(0);
        phase_sizes[3] = SIZE_W'(127);
        phase_sizes[4] = SIZE_W'(DEPTH + 1);
        phase_sizes[5] = SIZE_W'(1);
        phase_sizes[6] = SIZE_W'($urandom_range(3, DEPTH - 1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write every slot: run to full, one refused push, wrap into the last slot
        for (int i = 0; i < DEPTH; i++)
        begin
            send(REQ_PUSH, 8'($urandom_range(0, 255)), CNT_W'(1));
        end
        send(REQ_POP, 8'h00, CNT_W'(1));
        send(REQ_PUSH, 8'hFF, CNT_W'(1));
        // drain; the last burst stops on empty
        repeat (4) send(REQ_POP, 8'h00, CNT_W'(MAX_BURST));

        send(REQ_PUSH, 8'h00, CNT_W'(1));
        send(REQ_PUSH, 8'hAA, CNT_W'(1));
        send(REQ_PUSH, 8'h55, CNT_W'(1));
        send(REQ_PUSH, 8'hFF, CNT_W'(1));
        send(REQ_PEND_HEAD, 8'h00, '0);
        send(REQ_PEND_CONT, 8'h00, '1);
        send(REQ_CONFIRM, 8'h00, CNT_W'(1));
        send(REQ_POP, 8'h00, CNT_W'(MAX_BURST));
        for (int k = REQ_CONFIRM + 1; k <= REQ_CODE_MAX; k++)
        begin
            send(3'(k), 8'hFF, '1);
        end
        // stale look-ahead: confirm after pops moves the head back
        send(REQ_PUSH, 8'h11, CNT_W'(1));
        send(REQ_PUSH, 8'h22, CNT_W'(1));
        send(REQ_PUSH, 8'h33, CNT_W'(1));
        send(REQ_PEND_HEAD, 8'h00, CNT_W'(2));
        send(REQ_POP, 8'h00, CNT_W'(3));
        send(REQ_CONFIRM, 8'h00, CNT_W'(1));
        send(REQ_POP, 8'h00, CNT_W'(MAX_BURST));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_ring_size(phase_sizes[p]);
            calm = (p == 3);
            if (p == 1)
            begin
                hold_output = 1'b1;
                calm = 1'b1;
                repeat (20) send(REQ_PUSH, 8'($urandom_range(0, 255)), CNT_W'(1));
                calm = 1'b0;
            end
            repeat (PHASE_ITEMS) send_random();
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
